[sv/rsrb_pkg.sv]
package rsrb_pkg;

    localparam int MEM_RECORDS  = 16;
    localparam int KEY_BITS     = 32;
    localparam int PAYLOAD_BITS = 32;
    localparam int TAPE_W       = 5;
    localparam int IDX_W        = (MEM_RECORDS > 1) ? $clog2(MEM_RECORDS) : 1;
    localparam int OCC_W        = $clog2(MEM_RECORDS + 1);
    localparam int TREE_N       = 2 ** IDX_W;
    localparam int STEP_W       = $clog2(IDX_W + 1);

    localparam logic [TAPE_W-1:0] TAPE_COUNT_RESET = TAPE_W'(10);

    typedef logic [KEY_BITS-1:0]     t_key;
    typedef logic [PAYLOAD_BITS-1:0] t_payload;
    typedef logic [IDX_W-1:0]        t_idx;
    typedef logic [OCC_W-1:0]        t_occ;
    typedef logic [TAPE_W-1:0]       t_tape;

    // one entry of the minimum search
    typedef struct packed {
        logic v;
        t_key key;
        t_idx idx;
    } t_node;

    // commands from the controller to the datapath
    typedef struct packed {
        logic load_in;
        logic fill;
        logic tree_load;
        logic tree_step;
        logic new_run;
        logic tape_wrap;
        logic emit;
        logic last;
        logic replace;
        logic move;
        logic drain_done;
    } t_cmd;

    // status from the datapath to the controller
    typedef struct packed {
        logic full;
        logic empty;
        logic found;
        logic tape_over;
        logic out_free;
        logic last_one;
    } t_sts;

endpackage

[sv/replacement_selection_run_builder_core.sv]
// channel   dir  handshake                     content
// s_axis    in   s_axis_tvalid/s_axis_tready   record or drain request
// m_axis    out  m_axis_tvalid/m_axis_tready   record written to a run
// cfg       in   i_cfg_valid/o_cfg_ready       tape count register
//
// a record arriving while the store is not yet full is written straight into the store
// a record arriving on a full store yields its result after tree load, one
// comparator row per level of the 16-entry minimum search (4 levels), check
// and output load
// a new run adds a wrap check, the tape wrap subtractions and a second search
// a drain gives one result per search plus refill from the tail
// reset is synchronous active low; a stalled output holds its register and
// the controller waits in the emit state
module replacement_selection_run_builder_core import rsrb_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // input stream
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [KEY_BITS+PAYLOAD_BITS-1:0] s_axis_tdata,  // key, payload
    input  logic                 s_axis_tuser,              // mode
    // output stream
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [KEY_BITS+PAYLOAD_BITS-1:0] m_axis_tdata,  // out_key, out_payload
    output logic [TAPE_W:0]      m_axis_tuser,              // tape_index, run_start
    output logic                 m_axis_tlast,              // last
    // configuration
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [TAPE_W-1:0]    i_cfg_data                 // tape_count
);

    t_cmd     cmd;
    t_sts     sts;
    t_key     out_key;
    t_payload out_pay;
    t_tape    out_tape;
    logic     out_run_start;
    logic     in_ready;

    // register writes must only come while idle (the block does not enforce it)
    assign o_cfg_ready   = 1'b1;
    assign s_axis_tready = in_ready;

    // sequencer: fill, search, new run, emit, drain refill
    rsrb_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (in_ready),
        .i_in_mode  (s_axis_tuser),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    // record store, marks, comparator row, tape state and output register
    rsrb_dp u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_sts           (sts),
        .i_in_key        (s_axis_tdata[KEY_BITS-1:0]),
        .i_in_payload    (s_axis_tdata[KEY_BITS+PAYLOAD_BITS-1:KEY_BITS]),
        .i_cfg_valid     (i_cfg_valid),
        .i_cfg_data      (i_cfg_data),
        .o_out_valid     (m_axis_tvalid),
        .i_out_ready     (m_axis_tready),
        .o_out_key       (out_key),
        .o_out_payload   (out_pay),
        .o_out_tape      (out_tape),
        .o_out_run_start (out_run_start),
        .o_out_last      (m_axis_tlast)
    );

    // pack the result transaction, first field in the low bits
    assign m_axis_tdata = {out_pay, out_key};
    assign m_axis_tuser = {out_run_start, out_tape};

endmodule

[sv/rsrb_ctrl.sv]
module rsrb_ctrl import rsrb_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    input  logic i_in_mode,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_LOAD  = 7'b0000010,
        S_STEP  = 7'b0000100,
        S_CHECK = 7'b0001000,
        S_WRAP  = 7'b0010000,
        S_EMIT  = 7'b0100000,
        S_MOVE  = 7'b1000000
    } t_state;

    localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(IDX_W - 1);

    t_state              r_state, n_state;
    logic                r_drain, n_drain;
    logic [STEP_W-1:0]   r_step,  n_step;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_drain <= 1'b0;
            r_step  <= '0;
        end else begin
            r_state <= n_state;
            r_drain <= n_drain;
            r_step  <= n_step;
        end
    end

    always_comb begin
        n_state    = r_state;
        n_drain    = r_drain;
        n_step     = r_step;
        o_cmd      = '0;
        o_in_ready = (r_state == S_IDLE);
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load_in = 1'b1;
                    if (!i_in_mode) begin
                        if (!i_sts.full) begin
                            o_cmd.fill = 1'b1;
                        end else begin
                            n_drain = 1'b0;
                            n_state = S_LOAD;
                        end
                    end else if (i_sts.empty) begin
                        o_cmd.drain_done = 1'b1;
                    end else begin
                        n_drain = 1'b1;
                        n_state = S_LOAD;
                    end
                end
            end
            S_LOAD: begin
                o_cmd.tree_load = 1'b1;
                n_step          = '0;
                n_state         = S_STEP;
            end
            S_STEP: begin
                o_cmd.tree_step = 1'b1;
                if (r_step == STEP_LAST) begin
                    n_state = S_CHECK;
                end else begin
                    n_step = r_step + STEP_W'(1);
                end
            end
            S_CHECK: begin
                if (i_sts.found) begin
                    n_state = S_EMIT;
                end else begin
                    // every entry held: open a new run and search again
                    o_cmd.new_run = 1'b1;
                    n_state       = S_WRAP;
                end
            end
            S_WRAP: begin
                if (i_sts.tape_over) begin
                    o_cmd.tape_wrap = 1'b1;
                end else begin
                    n_state = S_LOAD;
                end
            end
            S_EMIT: begin
                if (i_sts.out_free) begin
                    o_cmd.emit = 1'b1;
                    o_cmd.last = r_drain & i_sts.last_one;
                    if (r_drain) begin
                        n_state = S_MOVE;
                    end else begin
                        o_cmd.replace = 1'b1;
                        n_state       = S_IDLE;
                    end
                end
            end
            S_MOVE: begin
                o_cmd.move = 1'b1;
                if (i_sts.last_one) begin
                    o_cmd.drain_done = 1'b1;
                    n_state          = S_IDLE;
                end else begin
                    n_state = S_LOAD;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

[sv/rsrb_dp.sv]
module rsrb_dp import rsrb_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_cmd     i_cmd,
    output t_sts     o_sts,
    input  t_key     i_in_key,
    input  t_payload i_in_payload,
    input  logic     i_cfg_valid,
    input  t_tape    i_cfg_data,
    output logic     o_out_valid,
    input  logic     i_out_ready,
    output t_key     o_out_key,
    output t_payload o_out_payload,
    output t_tape    o_out_tape,
    output logic     o_out_run_start,
    output logic     o_out_last
);

    t_key                   r_key [MEM_RECORDS];
    t_payload               r_pay [MEM_RECORDS];
    logic [MEM_RECORDS-1:0] r_mark;
    t_occ                   r_occ;
    t_tape                  r_tape;
    t_tape                  r_tape_count;
    logic                   r_run_open;
    t_key                   r_in_key;
    t_payload               r_in_pay;
    t_node                  r_node [TREE_N];
    logic                   r_out_valid;

    t_node    leaf [TREE_N];
    t_node    half [TREE_N/2];
    t_occ     occ_m1;
    t_idx     tail;
    t_idx     fill_idx;
    t_idx     rd_idx;
    t_key     rd_key;
    t_payload rd_pay;
    t_tape    tape_mod;

    assign occ_m1   = r_occ - OCC_W'(1);
    assign tail     = occ_m1[IDX_W-1:0];
    assign fill_idx = r_occ[IDX_W-1:0];
    assign rd_idx   = i_cmd.move ? tail : r_node[0].idx;
    assign rd_key   = r_key[rd_idx];
    assign rd_pay   = r_pay[rd_idx];
    assign tape_mod = (r_tape_count == '0) ? TAPE_W'(1) : r_tape_count;

    // leaves: occupied and not held for the next run
    for (genvar g = 0; g < TREE_N; g++) begin : g_leaf
        if (g < MEM_RECORDS) begin : g_used
            assign leaf[g] = '{v:   (OCC_W'(g) < r_occ) && !r_mark[g],
                               key: r_key[g],
                               idx: IDX_W'(g)};
        end else begin : g_pad
            assign leaf[g] = '{v: 1'b0, key: '0, idx: IDX_W'(g)};
        end
    end

    // one row of comparators, lower slot wins on equal keys
    always_comb begin
        for (int i = 0; i < TREE_N/2; i++) begin
            if (r_node[2*i+1].v && (!r_node[2*i].v || r_node[2*i+1].key < r_node[2*i].key)) begin
                half[i] = r_node[2*i+1];
            end else begin
                half[i] = r_node[2*i];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.tree_load) begin
            r_node <= leaf;
        end else if (i_cmd.tree_step) begin
            for (int i = 0; i < TREE_N/2; i++) begin
                r_node[i] <= half[i];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_in_key <= i_in_key;
            r_in_pay <= i_in_payload;
        end
        if (i_cmd.fill) begin
            r_key[fill_idx] <= i_in_key;
            r_pay[fill_idx] <= i_in_payload;
        end
        if (i_cmd.replace) begin
            r_key[r_node[0].idx] <= r_in_key;
            r_pay[r_node[0].idx] <= r_in_pay;
        end
        if (i_cmd.move) begin
            r_key[r_node[0].idx] <= rd_key;
            r_pay[r_node[0].idx] <= rd_pay;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mark       <= '0;
            r_occ        <= '0;
            r_tape       <= '0;
            r_tape_count <= TAPE_COUNT_RESET;
            r_run_open   <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_tape_count <= i_cfg_data;
            end
            if (i_cmd.fill) begin
                r_mark[fill_idx] <= 1'b0;
                r_occ            <= r_occ + OCC_W'(1);
            end
            if (i_cmd.new_run) begin
                r_mark     <= '0;
                r_tape     <= r_tape + TAPE_W'(1);
                r_run_open <= 1'b0;
            end
            if (i_cmd.tape_wrap) begin
                r_tape <= r_tape - tape_mod;
            end
            if (i_cmd.emit) begin
                r_run_open <= 1'b1;
            end
            if (i_cmd.replace) begin
                r_mark[r_node[0].idx] <= (r_in_key < r_node[0].key);
            end
            if (i_cmd.move) begin
                r_mark[r_node[0].idx] <= r_mark[tail];
                r_mark[tail]          <= 1'b0;
                r_occ                 <= occ_m1;
            end
            if (i_cmd.drain_done) begin
                r_tape     <= '0;
                r_run_open <= 1'b0;
            end
            if (i_cmd.emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            o_out_key       <= r_node[0].key;
            o_out_payload   <= rd_pay;
            o_out_tape      <= r_tape;
            o_out_run_start <= !r_run_open;
            o_out_last      <= i_cmd.last;
        end
    end

    assign o_out_valid = r_out_valid;

    assign o_sts.full      = (r_occ == OCC_W'(MEM_RECORDS));
    assign o_sts.empty     = (r_occ == '0);
    assign o_sts.found     = r_node[0].v;
    assign o_sts.tape_over = (r_tape >= tape_mod);
    assign o_sts.out_free  = !r_out_valid || i_out_ready;
    assign o_sts.last_one  = (r_occ == OCC_W'(1));

    a_occ_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_occ <= OCC_W'(MEM_RECORDS))
        else $error("store occupancy above capacity");

    a_emit_found: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.emit |-> r_node[0].v)
        else $error("result emitted without a selected entry");

    a_emit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.emit |-> (!r_out_valid || i_out_ready))
        else $error("output register overwritten");

    a_marks_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.new_run |=> (r_mark == '0))
        else $error("marks left after new run");

    a_fill_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.fill |-> (r_occ < OCC_W'(MEM_RECORDS)))
        else $error("fill into full store");

endmodule
